### rtl/rts_pkg.sv
package rts_pkg;

  // Fixed field widths
  localparam int CHAR_W     = 8;
  localparam int WORD_W     = 16;
  localparam int POS_BITS_D = 16;

  // Characters of interest
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
  localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;

  // Result kinds
  localparam logic [1:0] KIND_FOUND = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  // Redirection operator codes
  localparam logic [1:0] OP_IN      = 2'd0;
  localparam logic [1:0] OP_OUT     = 2'd1;
  localparam logic [1:0] OP_HEREDOC = 2'd2;
  localparam logic [1:0] OP_APPEND  = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        redir_type;
    logic [WORD_W-1:0] file_start;
    logic [WORD_W-1:0] word_length;
    logic              final_res;
  } out_item_t;

endpackage

### rtl/redirection_token_scanner.sv
// Redirection token scanner.
// The source channel (src_valid / src_stall / src_item) carries one character
// of a shell command line per item, with end_of_line set on its last one.
// The result channel (res_valid / res_stall / res_item) carries one item per
// redirection found (type, file start, word length), per syntax error, and
// one closing the line (final_res set).
// Throughput is one character per cycle while no result waits under
// res_stall. A character is held in the input register after its acceptance
// and scanned from it; its result, if any, is registered in the output
// register as the scan advances and can be taken from there.
// The scanner state advances only as the input register drains. While a
// result waits under res_stall, the input register holds its character and
// src_stall is raised whenever that register is full; no item is dropped.
// Reset (rst, synchronous) empties both registers and puts the scanner at the
// start of a line. Positions and lengths saturate at 2^POSITION_BITS - 1 and
// are reported in their low 16 bits.
module redirection_token_scanner import rts_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_D
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_item_t  src_item,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_item
);

  logic      hold_valid;
  in_item_t  hold_item;
  logic      advance;
  logic      scan_have;
  out_item_t scan_item;

  // Scan the held character when the output register can take a result
  assign advance   = hold_valid && (!res_valid || !res_stall);
  assign src_stall = hold_valid && !advance;

  rts_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (hold_item),
    .res_have (scan_have),
    .res_item (scan_item)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (src_valid && !src_stall) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      hold_item <= src_item;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && scan_have) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan_have) begin
      res_item <= scan_item;
    end
  end

endmodule

### rtl/rts_scan.sv
module rts_scan import rts_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_D
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  in_item_t  item,
  output logic      res_have,
  output out_item_t res_item
);

  typedef enum logic [2:0] {
    PH_SEEK,
    PH_PEND_GT,
    PH_PEND_LT,
    PH_SKIP,
    PH_WORD,
    PH_DEAD
  } phase_t;

  typedef logic [POSITION_BITS-1:0] pos_t;

  phase_t     phase, phase_next;
  logic       quote_is_single, quote_is_single_next;
  logic       quote_open, quote_open_next;
  logic [1:0] operator_code, operator_code_next;
  pos_t       position, position_next;
  pos_t       start_offset, start_offset_next;
  pos_t       length_count, length_count_next;

  logic       c_blank, c_quote, c_single, c_gt, c_lt, c_bslash;
  logic       single_op, run_skip, run_word, have;
  logic [1:0] kind;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == '1) ? v : pos_t'(v + 1'b1);
  endfunction

  // Character classes
  assign c_blank  = (item.character == CH_SPACE) || (item.character == CH_TAB) ||
                    (item.character == CH_NL);
  assign c_single = (item.character == CH_SQUOTE);
  assign c_quote  = c_single || (item.character == CH_DQUOTE);
  assign c_gt     = (item.character == CH_GT);
  assign c_lt     = (item.character == CH_LT);
  assign c_bslash = (item.character == CH_BSLASH);

  // Next state and result for one character
  always_comb begin
    phase_next           = phase;
    quote_is_single_next = quote_is_single;
    quote_open_next      = quote_open;
    operator_code_next   = operator_code;
    start_offset_next    = start_offset;
    length_count_next    = length_count;
    position_next        = sat_inc(position);
    have                 = 1'b0;
    kind                 = KIND_FOUND;
    single_op            = 1'b0;
    run_skip             = 1'b0;
    run_word             = 1'b0;

    case (phase)
      PH_SEEK: begin
        if (quote_open) begin
          if (quote_is_single ? c_single : (item.character == CH_DQUOTE)) begin
            quote_open_next = 1'b0;
          end
        end else if (c_quote) begin
          quote_open_next      = 1'b1;
          quote_is_single_next = c_single;
        end else if (c_gt) begin
          phase_next = PH_PEND_GT;
        end else if (c_lt) begin
          phase_next = PH_PEND_LT;
        end
      end
      PH_PEND_GT, PH_PEND_LT: begin
        single_op = (phase == PH_PEND_GT);
        if (single_op ? c_gt : c_lt) begin
          operator_code_next = {1'b1, single_op};
          phase_next         = PH_SKIP;
        end else begin
          operator_code_next = {1'b0, single_op};
          run_skip           = 1'b1;
        end
      end
      PH_SKIP: run_skip = 1'b1;
      PH_WORD: run_word = 1'b1;
      default: ;
    endcase

    // Blank skipping after an operator
    if (run_skip) begin
      if (c_blank) begin
        phase_next = PH_SKIP;
      end else if (c_bslash || c_lt || c_gt) begin
        have       = 1'b1;
        kind       = KIND_ERROR;
        phase_next = PH_DEAD;
      end else begin
        start_offset_next = position;
        length_count_next = '0;
        quote_open_next   = 1'b0;
        run_word          = 1'b1;
      end
    end

    // File word measurement
    if (run_word) begin
      phase_next = PH_WORD;
      if (quote_open_next) begin
        length_count_next = sat_inc(length_count_next);
        if (quote_is_single_next ? c_single : (item.character == CH_DQUOTE)) begin
          quote_open_next = 1'b0;
          have            = 1'b1;
          phase_next      = PH_SEEK;
        end
      end else if (c_quote) begin
        quote_open_next      = 1'b1;
        quote_is_single_next = c_single;
        length_count_next    = sat_inc(length_count_next);
      end else if (c_blank) begin
        have       = 1'b1;
        phase_next = PH_SEEK;
      end else if (c_lt) begin
        have       = 1'b1;
        phase_next = PH_PEND_LT;
      end else if (c_gt) begin
        have       = 1'b1;
        phase_next = PH_PEND_GT;
      end else begin
        length_count_next = sat_inc(length_count_next);
      end
    end

    // Line close
    if (item.end_of_line) begin
      case (phase_next)
        PH_PEND_GT, PH_PEND_LT, PH_SKIP: begin
          kind = KIND_ERROR;
        end
        PH_WORD: begin
          kind = KIND_FOUND;
        end
        default: begin
          if (!have) begin
            kind = KIND_END;
          end
        end
      endcase
      have = 1'b1;
    end

    res_have             = have;
    res_item.kind        = kind;
    res_item.final_res   = item.end_of_line;
    res_item.redir_type  = (kind == KIND_FOUND) ? operator_code_next : OP_IN;
    res_item.file_start  = (kind == KIND_FOUND) ? WORD_W'(start_offset_next) : '0;
    res_item.word_length = (kind == KIND_FOUND) ? WORD_W'(length_count_next) : '0;
  end

  // Scanner state, back to reset values after each line
  always_ff @(posedge clk) begin
    if (rst || (advance && item.end_of_line)) begin
      phase           <= PH_SEEK;
      quote_is_single <= 1'b0;
      quote_open      <= 1'b0;
      operator_code   <= OP_IN;
      position        <= '0;
      start_offset    <= '0;
      length_count    <= '0;
    end else if (advance) begin
      phase           <= phase_next;
      quote_is_single <= quote_is_single_next;
      quote_open      <= quote_open_next;
      operator_code   <= operator_code_next;
      position        <= position_next;
      start_offset    <= start_offset_next;
      length_count    <= length_count_next;
    end
  end

endmodule

### tb/redir_scan_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the scanner, predicts the results of every
// accepted character and compares them in order with the accepted results.
module redir_scan_checker import rts_pkg::*; #(
  parameter int POSITION_BITS = POS_BITS_D
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  input  logic      src_stall,
  input  in_item_t  src_item,
  input  logic      res_valid,
  input  logic      res_stall,
  input  out_item_t res_item,
  output int        fail_count,
  output int        pending_count
);

  typedef enum logic [2:0] {
    SCAN_SEEK,
    SCAN_PEND_GT,
    SCAN_PEND_LT,
    SCAN_SKIP,
    SCAN_WORD,
    SCAN_DEAD
  } scan_phase_t;

  // Predicted scanner state
  scan_phase_t              phase;
  logic                     q_single;
  logic                     q_open;
  logic [1:0]               op_code;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] file_start_r;
  logic [POSITION_BITS-1:0] word_len_r;

  out_item_t expected_results[$];
  int        result_index;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    result_index  = 0;
  end

  function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  task automatic clear_scan();
    phase        = SCAN_SEEK;
    q_single     = 1'b0;
    q_open       = 1'b0;
    op_code      = OP_IN;
    pos          = '0;
    file_start_r = '0;
    word_len_r   = '0;
  endtask

  // One character through the scanner: updates the state, returns a result if any
  task automatic scan_char(input in_item_t it, output logic have, output out_item_t res);
    logic [CHAR_W-1:0]        c;
    logic [POSITION_BITS-1:0] here;
    logic                     again;
    logic                     closing;
    logic                     gt;
    logic                     word_done;
    c         = it.character;
    here      = pos;
    have      = 1'b0;
    word_done = 1'b0;
    res       = '0;
    pos       = sat_inc(pos);
    again     = 1'b1;
    while (again) begin
      again   = 1'b0;
      closing = q_single ? (c == CH_SQUOTE) : (c == CH_DQUOTE);
      case (phase)
        SCAN_SEEK: begin
          if (q_open) begin
            if (closing) q_open = 1'b0;
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            q_open   = 1'b1;
            q_single = (c == CH_SQUOTE);
          end else if (c == CH_GT) begin
            phase = SCAN_PEND_GT;
          end else if (c == CH_LT) begin
            phase = SCAN_PEND_LT;
          end
        end
        // lookahead: doubled operator or the single one, rescanning c
        SCAN_PEND_GT, SCAN_PEND_LT: begin
          gt = (phase == SCAN_PEND_GT);
          if (c == (gt ? CH_GT : CH_LT)) begin
            op_code = gt ? OP_APPEND : OP_HEREDOC;
          end else begin
            op_code = gt ? OP_OUT : OP_IN;
            again   = 1'b1;
          end
          phase = SCAN_SKIP;
        end
        SCAN_SKIP: begin
          if (is_blank(c)) begin
          end else if (c == CH_BSLASH || c == CH_LT || c == CH_GT) begin
            have     = 1'b1;
            res.kind = KIND_ERROR;
            phase    = SCAN_DEAD;
          end else begin
            file_start_r = here;
            word_len_r   = '0;
            q_open       = 1'b0;
            phase        = SCAN_WORD;
            again        = 1'b1;
          end
        end
        SCAN_WORD: begin
          if (q_open) begin
            word_len_r = sat_inc(word_len_r);
            if (closing) begin
              q_open    = 1'b0;
              word_done = 1'b1;
            end
          end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
            q_open     = 1'b1;
            q_single   = (c == CH_SQUOTE);
            word_len_r = sat_inc(word_len_r);
          end else if (is_blank(c) || c == CH_LT || c == CH_GT) begin
            word_done = 1'b1;
            again     = (c == CH_LT || c == CH_GT);
          end else begin
            word_len_r = sat_inc(word_len_r);
          end
          if (word_done) begin
            have            = 1'b1;
            phase           = SCAN_SEEK;
            res.kind        = KIND_FOUND;
            res.redir_type  = op_code;
            res.file_start  = WORD_W'(file_start_r);
            res.word_length = WORD_W'(word_len_r);
          end
        end
        default: ;
      endcase
    end

    // closing the line
    if (it.end_of_line) begin
      case (phase)
        SCAN_PEND_GT, SCAN_PEND_LT, SCAN_SKIP: begin
          have     = 1'b1;
          res.kind = KIND_ERROR;
        end
        SCAN_WORD: begin
          have            = 1'b1;
          res.kind        = KIND_FOUND;
          res.redir_type  = op_code;
          res.file_start  = WORD_W'(file_start_r);
          res.word_length = WORD_W'(word_len_r);
        end
        default: begin
          if (!have) res.kind = KIND_END;
          have = 1'b1;
        end
      endcase
      if (res.kind != KIND_FOUND) begin
        res.redir_type  = OP_IN;
        res.file_start  = '0;
        res.word_length = '0;
      end
      res.final_res = 1'b1;
      clear_scan();
    end
  endtask

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= 50) $display("[%0t] result %0d: %s", $time, result_index, what);
  endtask

  // Channel monitor
  always @(posedge clk) begin
    logic      have;
    out_item_t pred;
    out_item_t want;
    if (rst) begin
      clear_scan();
      expected_results.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected");
        end else begin
          want = expected_results.pop_front();
          if (res_item.kind != want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", res_item.kind, want.kind));
          if (res_item.redir_type != want.redir_type)
            report_mismatch($sformatf("redir_type %0d, want %0d",
                                      res_item.redir_type, want.redir_type));
          if (res_item.file_start != want.file_start)
            report_mismatch($sformatf("file_start %0d, want %0d",
                                      res_item.file_start, want.file_start));
          if (res_item.word_length != want.word_length)
            report_mismatch($sformatf("word_length %0d, want %0d",
                                      res_item.word_length, want.word_length));
          if (res_item.final_res != want.final_res)
            report_mismatch($sformatf("final_res %0d, want %0d",
                                      res_item.final_res, want.final_res));
        end
        result_index++;
      end
      if (src_valid && !src_stall) begin
        scan_char(src_item, have, pred);
        if (have) expected_results.push_back(pred);
      end
    end
    pending_count = expected_results.size();
  end

endmodule

### tb/redirection_token_scanner_tb.sv
`timescale 1ns / 100ps

module redirection_token_scanner_tb import rts_pkg::*; ();

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 16;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_stall;
  in_item_t  src_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_item;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int sent_items = 0;
  int send_pct = 0;
  int recv_pct = 0;

  logic [CHAR_W-1:0] line_q[$];

  // Quoted spans, every operator, bad word starts, cut words, unclosed quotes
  string directed_lines [8] = '{
    "<a",
    ">>b<<c",
    "'<'>\"x\"",
    "> \t\n\\z",
    ">",
    ">a<",
    "'x",
    "<'a"
  };

  always #1 clk = ~clk;

  redirection_token_scanner u_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  redir_scan_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_stall     (src_stall),
    .src_item      (src_item),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .res_item      (res_item),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** redirection_token_scanner: FAILED **");
      $finish;
    end
  end

  // Random receiver stall
  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else res_stall <= ($urandom_range(99) < recv_pct);
  end

  function automatic logic is_special(input logic [CHAR_W-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_DQUOTE ||
           c == CH_SQUOTE || c == CH_LT || c == CH_GT;
  endfunction

  // Mostly plain file-name characters, now and then any ordinary byte
  function automatic logic [CHAR_W-1:0] word_char();
    string             alnum;
    logic [CHAR_W-1:0] c;
    alnum = "abcdefghijklmnopqrstuvwxyz0123456789._-/";
    if ($urandom_range(9) != 0) return alnum[$urandom_range(alnum.len() - 1)];
    do c = CHAR_W'($urandom_range(255, 1)); while (is_special(c));
    return c;
  endfunction

  // Any nonzero byte, biased toward the ones the scanner cares about
  function automatic logic [CHAR_W-1:0] noise_char();
    if ($urandom_range(9) < 4) begin
      case ($urandom_range(7))
        0: return CH_DQUOTE;
        1: return CH_SQUOTE;
        2: return CH_GT;
        3: return CH_LT;
        4: return CH_BSLASH;
        5: return CH_SPACE;
        6: return CH_TAB;
        default: return CH_NL;
      endcase
    end
    return CHAR_W'($urandom_range(255, 1));
  endfunction

  function automatic logic [CHAR_W-1:0] quote_char();
    return $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
  endfunction

  task automatic add_str(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic add_blanks(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) begin
      case ($urandom_range(3))
        0: line_q.push_back(CH_TAB);
        1: line_q.push_back(CH_NL);
        default: line_q.push_back(CH_SPACE);
      endcase
    end
  endtask

  task automatic add_plain(input int lo, input int hi);
    repeat ($urandom_range(hi, lo)) line_q.push_back(word_char());
  endtask

  task automatic add_quoted();
    logic [CHAR_W-1:0] q;
    logic [CHAR_W-1:0] c;
    q = quote_char();
    line_q.push_back(q);
    repeat ($urandom_range(3)) begin
      c = noise_char();
      line_q.push_back(c == q ? word_char() : c);
    end
    line_q.push_back(q);
  endtask

  task automatic add_operator();
    case ($urandom_range(3))
      0: add_str("<");
      1: add_str(">");
      2: add_str("<<");
      default: add_str(">>");
    endcase
  endtask

  task automatic add_redirection();
    add_operator();
    add_blanks(0, 2);
    case ($urandom_range(3))
      0, 1: add_plain(1, 5);
      2: begin
        add_quoted();
        add_plain(0, 2);
      end
      default: begin
        add_plain(1, 2);
        add_quoted();
      end
    endcase
  endtask

  // A line of words, quoted spans and redirections
  task automatic build_wellformed();
    repeat ($urandom_range(5, 1)) begin
      case ($urandom_range(3))
        0: add_plain(1, 4);
        1: add_quoted();
        default: add_redirection();
      endcase
      if ($urandom_range(9) < 7) add_blanks(1, 2);
    end
  endtask

  // Noise, dangling operators, bad word starts, unclosed quotes
  task automatic build_broken();
    case ($urandom_range(3))
      0: repeat ($urandom_range(10, 1)) line_q.push_back(noise_char());
      1: begin
        if ($urandom_range(1)) build_wellformed();
        add_operator();
        add_blanks(0, 2);
      end
      2: begin
        add_operator();
        add_blanks(0, 1);
        case ($urandom_range(2))
          0: line_q.push_back(CH_BSLASH);
          1: line_q.push_back(CH_LT);
          default: line_q.push_back(CH_GT);
        endcase
        repeat ($urandom_range(4)) line_q.push_back(noise_char());
      end
      default: begin
        if ($urandom_range(1)) begin
          add_operator();
          add_blanks(0, 1);
        end
        line_q.push_back(quote_char());
        add_plain(0, 4);
      end
    endcase
  endtask

  // One item, after a random idle gap of the sender
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic eol);
    if ($urandom_range(99) < send_pct) begin
      src_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    src_valid <= 1'b1;
    src_item  <= '{character: c, end_of_line: eol};
    do @(posedge clk); while (src_stall);
    sent_items++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  task automatic run_random(input int n_items);
    int stop;
    stop = sent_items + n_items;
    while (sent_items < stop) begin
      if ($urandom_range(9) < 8) build_wellformed();
      else build_broken();
      send_line();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_pct = 15;
    recv_pct = 67;
    foreach (directed_lines[i]) begin
      add_str(directed_lines[i]);
      send_line();
    end
    line_q.push_back(8'hFF);
    send_line();
    run_random(700);

    send_pct = 67;
    recv_pct = 15;
    run_random(700);

    send_pct = 0;
    recv_pct = 0;
    run_random(600);
    src_valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_count != 0) $display("%0d results never arrived", pending_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("** redirection_token_scanner: PASSED **");
    end else begin
      $display("** redirection_token_scanner: FAILED **");
    end
    $finish;
  end

endmodule
